// ----- hdl/tkpc_pkg.sv -----
// Package for the top-k by play count selector.
// Holds the field widths, the slot record and the cell control struct.
// No dependencies.
package tkpc_pkg;

  localparam int KeyW   = 32;
  localparam int TagW   = 5;
  localparam int LimW   = 5;
  localparam int RankW  = 4;
  localparam int EmitCap = 16;

  localparam logic [LimW-1:0] LimitReset = LimW'(5);

  // One held record of the ranking chain
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [TagW-1:0] tag;
  } slot_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the incoming record
    logic pop;  // shift the chain toward cell 0
    logic clr;  // drop every held record
  } cell_ctrl_t;

endpackage

// ----- hdl/tkpc_cell.sv -----
// One compare-and-insert cell of the ranking chain.
// Depends on tkpc_pkg for slot_t and cell_ctrl_t.
module tkpc_cell
  import tkpc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cell_ctrl_t      ctrl_i,
  input  logic [KeyW-1:0] new_key_i,
  input  logic [TagW-1:0] new_tag_i,
  input  logic            prev_ge_i,
  input  slot_t           prev_i,
  input  slot_t           next_i,
  output logic            ge_o,
  output slot_t           slot_o
);

  logic            valid_q;
  logic [KeyW-1:0] key_q;
  logic [TagW-1:0] tag_q;
  slot_t           slot_cur, slot_d;

  assign slot_cur = '{valid: valid_q, key: key_q, tag: tag_q};

  // Held record ranks at or above the new one: ties keep arrival order
  assign ge_o   = slot_cur.valid && (slot_cur.key >= new_key_i);
  assign slot_o = slot_cur;

  // Pick the next content: clear, pop from the right, or insert/shift
  always_comb begin
    slot_d = slot_cur;
    if (ctrl_i.clr) begin
      slot_d.valid = 1'b0;
    end else if (ctrl_i.pop) begin
      slot_d = next_i;
    end else if (ctrl_i.ins) begin
      if (!prev_ge_i) begin
        slot_d = prev_i;
      end else if (!ge_o) begin
        slot_d.valid = 1'b1;
        slot_d.key   = new_key_i;
        slot_d.tag   = new_tag_i;
      end
    end
  end

  // Hold the valid bit under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= slot_d.valid;
    end
  end

  // Hold the payload
  always_ff @(posedge clk_i) begin
    key_q <= slot_d.key;
    tag_q <= slot_d.tag;
  end

endmodule

// ----- hdl/top_k_by_play_count.sv -----
// Top level of the top-k by play count selector: control and the cell chain.
// Depends on tkpc_pkg and tkpc_cell.
//
// A record is taken in every cycle while busy_o is low, and enters a
// chain of MAX_REPORT compare-and-insert cells in that same cycle. On
// the record that carries last_record_i the block raises busy_o while
// it presents n results, n = min(limit clamped to 1..min(MAX_REPORT, 16),
// records kept in the batch), one result per cycle on result_valid_o,
// best first, by shifting the chain toward cell 0; the receiver cannot
// stall, so each result is on the ports for exactly one cycle. Records
// past MAX_RECORDS are dropped and set overflowed_o for the batch. The
// limit register is written through the cfg channel, which is always
// ready; write it only while the block is idle.
module top_k_by_play_count
  import tkpc_pkg::*;
#(
  parameter int MAX_REPORT  = 16,
  parameter int MAX_RECORDS = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  // record channel
  input  logic             start_i,
  output logic             busy_o,
  input  logic [KeyW-1:0]  play_count_i,
  input  logic [TagW-1:0]  record_tag_i,
  input  logic             last_record_i,
  // configuration channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [LimW-1:0]  cfg_data_i,
  // result channel
  output logic             result_valid_o,
  output logic [RankW-1:0] rank_o,
  output logic [TagW-1:0]  best_tag_o,
  output logic [KeyW-1:0]  best_count_o,
  output logic             overflowed_o,
  output logic             final_result_o
);

  localparam int CntW   = $clog2(MAX_RECORDS + 1);
  localparam int CmpW   = (CntW > LimW) ? CntW : LimW;
  localparam int CapVal = (MAX_REPORT < EmitCap) ? MAX_REPORT : EmitCap;
  localparam logic [LimW-1:0] LimCap = LimW'(CapVal);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic            state_q, state_d;
  logic [CntW-1:0] seen_q, seen_d;
  logic            drop_q, drop_d;
  logic [RankW-1:0] cnt_q, cnt_d;
  logic [LimW-1:0] n_q, n_d;
  logic [LimW-1:0] limit_q;

  logic            accept;
  logic            full;
  logic [CntW-1:0] seen_new;
  logic [LimW-1:0] lim_eff;
  logic            last_out;
  cell_ctrl_t      ctrl;

  slot_t           slot_w [MAX_REPORT];
  slot_t           chain_w [MAX_REPORT+2];
  logic [MAX_REPORT-1:0] ge_w;
  logic [MAX_REPORT-1:0] prev_ge_w;
  logic [MAX_REPORT-1:0] valid_w;

  assign accept      = start_i && !busy_o;
  assign busy_o      = (state_q == ST_EMIT);
  assign cfg_ready_o = 1'b1;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Clamp the limit to the range the chain can report
  always_comb begin
    lim_eff = limit_q;
    if (limit_q == '0) begin
      lim_eff = LimW'(1);
    end else if (limit_q > LimCap) begin
      lim_eff = LimCap;
    end
  end

  assign full     = (seen_q >= CntW'(MAX_RECORDS));
  assign seen_new = full ? seen_q : (seen_q + CntW'(1));
  assign last_out = busy_o && ({1'b0, cnt_q} == (n_q - LimW'(1)));

  // Sequence the batch: collect records, then emit the ranked list
  always_comb begin
    state_d  = state_q;
    seen_d   = seen_q;
    drop_d   = drop_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    ctrl     = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (full) begin
            drop_d = 1'b1;
          end else begin
            seen_d   = seen_new;
            ctrl.ins = 1'b1;
          end
          if (last_record_i) begin
            state_d = ST_EMIT;
            cnt_d   = '0;
            if (CmpW'(seen_new) < CmpW'(lim_eff)) begin
              n_d = LimW'(CmpW'(seen_new));
            end else begin
              n_d = lim_eff;
            end
          end
        end
      end
      ST_EMIT: begin
        ctrl.pop = 1'b1;
        cnt_d    = cnt_q + RankW'(1);
        if (last_out) begin
          ctrl.clr = 1'b1;
          state_d  = ST_IDLE;
          seen_d   = '0;
          drop_d   = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      drop_q  <= 1'b0;
      cnt_q   <= '0;
      n_q     <= LimW'(1);
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      drop_q  <= drop_d;
      cnt_q   <= cnt_d;
      n_q     <= n_d;
    end
  end

  // Chain ends: nothing to the left of cell 0, an empty slot past the end
  assign chain_w[0]            = '0;
  assign chain_w[MAX_REPORT+1] = '0;

  for (genvar i = 0; i < MAX_REPORT; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev_ge_w[i] = 1'b1;
    end else begin : g_body
      assign prev_ge_w[i] = ge_w[i-1];
    end
    assign chain_w[i+1] = slot_w[i];
    assign valid_w[i]   = slot_w[i].valid;

    tkpc_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .new_key_i (play_count_i),
      .new_tag_i (record_tag_i),
      .prev_ge_i (prev_ge_w[i]),
      .prev_i    (chain_w[i]),
      .next_i    (chain_w[i+2]),
      .ge_o      (ge_w[i]),
      .slot_o    (slot_w[i])
    );
  end

  // Result tag and count come straight from cell 0
  assign result_valid_o = busy_o;
  assign rank_o         = cnt_q;
  assign best_tag_o     = slot_w[0].tag;
  assign best_count_o   = slot_w[0].key;
  assign overflowed_o   = drop_q;
  assign final_result_o = last_out;

  // A batch ending with a record always starts emitting next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && last_record_i |=> result_valid_o)
    else $error("no result after last record");

  // Every emitted result reads a held record
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> slot_w[0].valid)
    else $error("emitted an empty slot");

  // Emission runs without gaps up to the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !final_result_o |=> result_valid_o)
    else $error("emission stopped before final result");

  // The list is empty once the batch is reported
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    final_result_o |=> (valid_w == '0) && (seen_q == '0) && !overflowed_o)
    else $error("state not cleared after batch");

endmodule

// ----- tb/top_k_by_play_count_test.sv -----
// Self-checking testbench for top_k_by_play_count: drives record batches and limit writes.
// Predicts each batch ranking in the bench and checks every emitted result; needs tkpc_pkg and
// the top_k_by_play_count RTL.
`timescale 1ns / 1ps

module top_k_by_play_count_test;
  import tkpc_pkg::*;

  localparam int MaxReport  = 16;
  localparam int MaxRecords = 32;
  localparam int CycleLimit = 200000;
  localparam int PhaseItems = 45;

  // One record transaction and one ranked result
  typedef struct {
    logic [KeyW-1:0] count;
    logic [TagW-1:0] tag;
    logic            last;
  } play_record_t;

  typedef struct {
    logic [RankW-1:0] rank;
    logic [TagW-1:0]  tag;
    logic [KeyW-1:0]  count;
    logic             dropped;
    logic             final_one;
  } rank_entry_t;

  typedef enum int {
    KeyFull,
    KeyTies,
    KeyEdges
  } key_mode_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [KeyW-1:0]  play_count_i = '0;
  logic [TagW-1:0]  record_tag_i = '0;
  logic             last_record_i = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [LimW-1:0]  cfg_data_i = '0;
  logic             result_valid_o;
  logic [RankW-1:0] rank_o;
  logic [TagW-1:0]  best_tag_o;
  logic [KeyW-1:0]  best_count_o;
  logic             overflowed_o;
  logic             final_result_o;

  top_k_by_play_count #(
    .MAX_REPORT (MaxReport),
    .MAX_RECORDS(MaxRecords)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .play_count_i  (play_count_i),
    .record_tag_i  (record_tag_i),
    .last_record_i (last_record_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .rank_o        (rank_o),
    .best_tag_o    (best_tag_o),
    .best_count_o  (best_count_o),
    .overflowed_o  (overflowed_o),
    .final_result_o(final_result_o)
  );

  // Bench copy of the ranking chain and the limit register
  logic [KeyW-1:0] chain_keys [MaxReport];
  logic [TagW-1:0] chain_tags [MaxReport];
  int              chain_fill = 0;
  int              batch_count = 0;
  logic            batch_dropped = 1'b0;
  logic [LimW-1:0] limit_reg = LimitReset;

  play_record_t pending_records[$];
  rank_entry_t  expected_ranking[$];
  int           mismatch_num = 0;
  int           accepted_num = 0;
  int           queued_num = 0;
  int           cycle_num = 0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input logic [KeyW-1:0] got,
                                 input logic [KeyW-1:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_num++;
  endtask

  // Insert one record behind every held key that is greater or equal
  task automatic insert_ranked(input logic [KeyW-1:0] key, input logic [TagW-1:0] tag);
    int pos;
    int i;
    pos = 0;
    while (pos < chain_fill && chain_keys[pos] >= key) pos++;
    if (pos >= MaxReport) return;
    i = (chain_fill < MaxReport) ? chain_fill : MaxReport - 1;
    while (i > pos) begin
      chain_keys[i] = chain_keys[i-1];
      chain_tags[i] = chain_tags[i-1];
      i--;
    end
    chain_keys[pos] = key;
    chain_tags[pos] = tag;
    if (chain_fill < MaxReport) chain_fill++;
  endtask

  // Advance the bench chain by one accepted record; emit the ranking on the last one
  task automatic rank_record(input play_record_t rec);
    int          n;
    rank_entry_t res;
    if (batch_count >= MaxRecords) begin
      batch_dropped = 1'b1;
    end else begin
      batch_count++;
      insert_ranked(rec.count, rec.tag);
    end
    if (!rec.last) return;
    n = int'(limit_reg);
    if (n == 0) n = 1;
    if (n > MaxReport) n = MaxReport;
    if (n > EmitCap) n = EmitCap;
    if (n > batch_count) n = batch_count;
    if (n > chain_fill) n = chain_fill;
    for (int k = 0; k < n; k++) begin
      res.rank      = RankW'(k);
      res.tag       = chain_tags[k];
      res.count     = chain_keys[k];
      res.dropped   = batch_dropped;
      res.final_one = (k + 1 == n);
      expected_ranking.push_back(res);
    end
    chain_fill    = 0;
    batch_count   = 0;
    batch_dropped = 1'b0;
  endtask

  // Driver: retire the accepted transaction, then present the next record or idle
  always @(posedge clk_i) begin : record_driver
    logic calm;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else begin
      if (start_i && !busy_o) begin
        rank_record(pending_records.pop_front());
        accepted_num++;
      end
      calm = (accepted_num >= 150 && accepted_num < 260);
      if (pending_records.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
        start_i       <= 1'b1;
        play_count_i  <= pending_records[0].count;
        record_tag_i  <= pending_records[0].tag;
        last_record_i <= pending_records[0].last;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check each strobed result against the oldest expectation
  always @(posedge clk_i) begin : rank_monitor
    rank_entry_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_ranking.size() == 0) begin
        report_mismatch("unexpected result, rank", KeyW'(rank_o), '0);
      end else begin
        want = expected_ranking.pop_front();
        if (rank_o !== want.rank) report_mismatch("rank", KeyW'(rank_o), KeyW'(want.rank));
        if (best_tag_o !== want.tag)
          report_mismatch("best_tag", KeyW'(best_tag_o), KeyW'(want.tag));
        if (best_count_o !== want.count) report_mismatch("best_count", best_count_o, want.count);
        if (overflowed_o !== want.dropped)
          report_mismatch("overflowed", KeyW'(overflowed_o), KeyW'(want.dropped));
        if (final_result_o !== want.final_one)
          report_mismatch("final_result", KeyW'(final_result_o), KeyW'(want.final_one));
      end
    end
  end

  // Watchdog: end the run if it never drains
  initial begin
    while (cycle_num < CycleLimit) begin
      @(posedge clk_i);
      cycle_num++;
    end
    $display("Verification failed");
    $finish;
  end

  task automatic queue_record(input logic [KeyW-1:0] count, input logic [TagW-1:0] tag,
                              input logic last);
    play_record_t rec;
    rec.count = count;
    rec.tag   = tag;
    rec.last  = last;
    pending_records.push_back(rec);
    queued_num++;
  endtask

  function automatic logic [KeyW-1:0] pick_key(input key_mode_e mode);
    case (mode)
      KeyTies: begin
        return KeyW'($urandom_range(7));
      end
      KeyEdges: begin
        case ($urandom_range(4))
          0: return '0;
          1: return '1;
          2: return 32'h8000_0000;
          3: return 32'h7FFF_FFFF;
          default: return $urandom;
        endcase
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  // Queue one batch; most are short, some fill the chain, some run past capacity
  task automatic queue_batch();
    int        len;
    int        sel;
    key_mode_e mode;
    sel = $urandom_range(7);
    if (sel == 0) len = $urandom_range(MaxRecords + 6, MaxRecords + 1);
    else if (sel == 1) len = $urandom_range(MaxRecords, MaxReport + 1);
    else len = $urandom_range(MaxReport, 1);
    case ($urandom_range(2))
      0: mode = KeyFull;
      1: mode = KeyTies;
      default: mode = KeyEdges;
    endcase
    for (int i = 0; i < len; i++)
      queue_record(pick_key(mode), TagW'($urandom_range(31)), i == len - 1);
  endtask

  // Wait until every record is taken and every result has come, then let the block settle
  task automatic settle();
    int guard;
    guard = 0;
    while ((pending_records.size() > 0 || expected_ranking.size() > 0 || start_i)
           && guard < 20000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  // Write the limit register through its channel; only call while idle
  task automatic write_limit(input logic [LimW-1:0] value);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    limit_reg = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Reset, directed batches, then random batches under a series of limits
  initial begin
    logic [LimW-1:0] limits[8];
    int              phase_start;
    limits = '{LimW'(0), LimW'(1), LimW'(16), LimW'(31), LimW'(17),
               LimW'($urandom_range(15, 2)), LimW'(8), LimW'(5)};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // single-record batches at the key and tag extremes
    queue_record('1, TagW'(31), 1'b1);
    queue_record('0, TagW'(0), 1'b1);
    // equal keys keep arrival order
    queue_record(32'd7, TagW'(1), 1'b0);
    queue_record(32'd7, TagW'(2), 1'b0);
    queue_record(32'd7, TagW'(3), 1'b0);
    queue_record(32'd9, TagW'(4), 1'b0);
    queue_record(32'd7, TagW'(5), 1'b1);
    // more records than the reset limit reports
    queue_record('1, TagW'(10), 1'b0);
    queue_record('0, TagW'(11), 1'b0);
    queue_record(32'h8000_0000, TagW'(12), 1'b0);
    queue_record(32'h7FFF_FFFF, TagW'(13), 1'b0);
    queue_record(32'd1, TagW'(14), 1'b0);
    queue_record(32'hFFFF_FFFE, TagW'(15), 1'b0);
    queue_record(32'h1234_5678, TagW'(16), 1'b1);
    settle();

    // each phase: write the limit while idle, then pause until its results drain
    foreach (limits[p]) begin
      write_limit(limits[p]);
      @(negedge clk_i);
      phase_start = queued_num;
      while (queued_num - phase_start < PhaseItems) queue_batch();
      settle();
    end

    if (expected_ranking.size() != 0)
      report_mismatch("results never emitted, count", expected_ranking.size(), '0);
    repeat (8) @(posedge clk_i);
    if (mismatch_num == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
